// File: src/lrup_pkg.sv
// shared types and constants for the lru page replacement block
// no dependencies; used by the controller, the datapath and the top level
package lrup_pkg;

  localparam int PAGE_BITS = 20;
  localparam int CFG_W = 5;
  localparam int SLOT_W = 4;
  localparam int COUNT_W = 32;
  localparam int MAX_FRAMES_DEF = 16;
  localparam logic [CFG_W-1:0] FRAMES_RESET = 5'd4;

  typedef struct packed {
    logic [PAGE_BITS-1:0] page_number;
    logic                 last_request;
  } lrup_req_t;

  typedef struct packed {
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic                 evicted_valid;
    logic [PAGE_BITS-1:0] evicted_page;
    logic [COUNT_W-1:0]   fault_total;
    logic                 string_done;
  } lrup_res_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic lookup;
    logic scan;
    logic update;
    logic load_out;
  } lrup_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit_any;
    logic empty_any;
    logic scan_last;
  } lrup_sts_t;

endpackage

// File: src/lru_page_replacement.sv
// top level of the lru page replacement block
// depends on lrup_pkg, lrup_ctrl and lrup_datapath
//
//  channel  ports                          direction  moves
//  in       in_valid, in_stall, in_req     in         one page reference request
//  out      out_valid, out_stall, out_res  out        one result per request
//  cfg      cfg_wr_en, cfg_wr_data         in         frames_in_use, no read-back
//
// a request on a hit or when an empty frame is filled goes through capture,
// lookup, update and output load; a replacement adds a victim scan over the
// active frames, one rank read per cycle
// synchronous reset empties all frames, clears ranks and the fault count and
// sets frames_in_use to 4; there is no clearing pass
// the output register lets the next request in while a result is stalled
module lru_page_replacement #(
  parameter int MAX_FRAMES = lrup_pkg::MAX_FRAMES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  lrup_pkg::lrup_req_t        in_req,
  output logic                       out_valid,
  input  logic                       out_stall,
  output lrup_pkg::lrup_res_t        out_res,
  input  logic                       cfg_wr_en,
  input  logic [lrup_pkg::CFG_W-1:0] cfg_wr_data
);

  lrup_pkg::lrup_cmd_t cmd;
  lrup_pkg::lrup_sts_t sts;

  lrup_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lrup_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_req      (in_req),
    .cmd         (cmd),
    .sts         (sts),
    .out_res     (out_res)
  );

endmodule

// File: src/lrup_ctrl.sv
// sequencing state machine for the lru page replacement block
// depends on lrup_pkg for the command and status structs
module lrup_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  lrup_pkg::lrup_sts_t sts,
  output lrup_pkg::lrup_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        // full miss needs a victim search over the active frames
        state_nxt  = (sts.hit_any || sts.empty_any) ? S_UPD : S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: src/lrup_datapath.sv
// frame table, recency ranks, fault counter and result registers
// depends on lrup_pkg; driven by commands from lrup_ctrl
module lrup_datapath #(
  parameter int MAX_FRAMES = lrup_pkg::MAX_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [lrup_pkg::CFG_W-1:0]   cfg_wr_data,
  input  lrup_pkg::lrup_req_t          in_req,
  input  lrup_pkg::lrup_cmd_t          cmd,
  output lrup_pkg::lrup_sts_t          sts,
  output lrup_pkg::lrup_res_t          out_res
);

  localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int NW = $clog2(MAX_FRAMES + 1);
  localparam int CW = (NW > lrup_pkg::CFG_W) ? NW : lrup_pkg::CFG_W;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_FRAMES);
  localparam int PW = lrup_pkg::PAGE_BITS;
  localparam int KW = lrup_pkg::COUNT_W;
  localparam int SW = lrup_pkg::SLOT_W;

  // control state
  logic [lrup_pkg::CFG_W-1:0] frames_r;
  logic [MAX_FRAMES-1:0]      valid_r;
  logic [IW-1:0]              rank_r [MAX_FRAMES];
  logic [KW-1:0]              count_r;

  // payload state
  logic [PW-1:0]              page_r [MAX_FRAMES];
  lrup_pkg::lrup_req_t        req_r;
  logic                       hit_r;
  logic                       fill_r;
  logic [IW-1:0]              slot_r;
  logic [IW-1:0]              old_rank_r;
  logic [PW-1:0]              evp_r;
  logic [IW-1:0]              scan_idx_r;
  lrup_pkg::lrup_res_t        res_r;
  lrup_pkg::lrup_res_t        out_res_r;

  logic [CW-1:0]              cfg_ext;
  logic [CW-1:0]              n_eff;
  logic [CW-1:0]              n_m1;
  logic [IW-1:0]              last_idx;
  logic                       hit_any;
  logic                       empty_any;
  logic [IW-1:0]              hit_idx;
  logic [IW-1:0]              empty_idx;
  logic [IW-1:0]              hit_rank;
  logic [IW-1:0]              scan_rank;
  logic [KW-1:0]              fault_new;
  logic                       evict;
  logic [IW+SW-1:0]           slot_wide;

  // zero frames acts as one, anything above the table size as the table size
  assign cfg_ext = CW'(frames_r);
  always_comb begin
    if (cfg_ext == '0) begin
      n_eff = CW'(1);
    end else if (cfg_ext > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = cfg_ext;
    end
  end
  assign n_m1     = n_eff - CW'(1);
  assign last_idx = n_m1[IW-1:0];

  // parallel compare over the active frames, lowest index wins
  always_comb begin
    hit_any   = 1'b0;
    empty_any = 1'b0;
    hit_idx   = '0;
    empty_idx = '0;
    hit_rank  = '0;
    for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
      if (CW'(i) < n_eff) begin
        if (valid_r[i] && (page_r[i] == req_r.page_number)) begin
          hit_any  = 1'b1;
          hit_idx  = IW'(i);
          hit_rank = rank_r[i];
        end else if (!valid_r[i]) begin
          empty_any = 1'b1;
          empty_idx = IW'(i);
        end
      end
    end
  end

  assign scan_rank     = rank_r[scan_idx_r];
  assign sts.hit_any   = hit_any;
  assign sts.empty_any = empty_any;
  assign sts.scan_last = (scan_idx_r == last_idx);

  assign fault_new = (!hit_r && (count_r != {KW{1'b1}})) ? count_r + KW'(1) : count_r;
  assign evict     = !hit_r && !fill_r;
  assign slot_wide = {{SW{1'b0}}, slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= lrup_pkg::FRAMES_RESET;
      valid_r  <= '0;
      count_r  <= '0;
      for (int i = 0; i < MAX_FRAMES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        frames_r <= cfg_wr_data;
      end
      if (cmd.update) begin
        count_r <= req_r.last_request ? '0 : fault_new;
        for (int i = 0; i < MAX_FRAMES; i++) begin
          if (req_r.last_request) begin
            valid_r[i] <= 1'b0;
            rank_r[i]  <= '0;
          end else if (IW'(i) == slot_r) begin
            valid_r[i] <= 1'b1;
            rank_r[i]  <= '0;
          end else if (valid_r[i] && (fill_r || (rank_r[i] < old_rank_r))) begin
            // frames newer than the promoted one age by one; on a fill every live frame does
            rank_r[i] <= rank_r[i] + IW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_req;
    end
    if (cmd.lookup) begin
      hit_r      <= hit_any;
      fill_r     <= !hit_any && empty_any;
      slot_r     <= hit_any ? hit_idx : empty_idx;
      old_rank_r <= hit_rank;
      scan_idx_r <= '0;
    end
    // victim search: oldest active frame, first one on a tie
    if (cmd.scan) begin
      if ((scan_idx_r == '0) || (scan_rank > old_rank_r)) begin
        slot_r     <= scan_idx_r;
        old_rank_r <= scan_rank;
        evp_r      <= page_r[scan_idx_r];
      end
      scan_idx_r <= scan_idx_r + IW'(1);
    end
    if (cmd.update) begin
      if (!hit_r) begin
        page_r[slot_r] <= req_r.page_number;
      end
      res_r.hit           <= hit_r;
      res_r.slot          <= slot_wide[SW-1:0];
      res_r.evicted_valid <= evict;
      res_r.evicted_page  <= evict ? evp_r : '0;
      res_r.fault_total   <= fault_new;
      res_r.string_done   <= req_r.last_request;
    end
    if (cmd.load_out) begin
      out_res_r <= res_r;
    end
  end

  assign out_res = out_res_r;

endmodule

// File: sim/lrup_checker.sv
`timescale 1ns / 1ps
// passive checker for lru_page_replacement: keeps its own frame table, works out each result
// as a request is taken and compares it with the out channel; depends on lrup_pkg
module lrup_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  lrup_pkg::lrup_req_t        in_req,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  lrup_pkg::lrup_res_t        out_res,
  input  logic                       cfg_wr_en,
  input  logic [lrup_pkg::CFG_W-1:0] cfg_wr_data,
  output int unsigned                mismatch_count,
  output int unsigned                pending_count
);

  localparam int NFRAMES = lrup_pkg::MAX_FRAMES_DEF;
  localparam int REPORT_LIMIT = 30;
  localparam int PW = lrup_pkg::PAGE_BITS;
  localparam int SW = lrup_pkg::SLOT_W;
  localparam int KW = lrup_pkg::COUNT_W;

  logic [PW-1:0]              frame_tag [NFRAMES];
  logic                       frame_live [NFRAMES];
  logic [SW-1:0]              frame_age [NFRAMES];
  logic [KW-1:0]              faults_seen;
  logic [lrup_pkg::CFG_W-1:0] frames_setting;
  lrup_pkg::lrup_res_t        pending_outcomes [$];
  int unsigned                errors;

  function automatic void empty_frames();
    for (int i = 0; i < NFRAMES; i++) begin
      frame_tag[i] = '0;
      frame_live[i] = 1'b0;
      frame_age[i] = '0;
    end
    faults_seen = '0;
  endfunction

  // age 0 is newest; a freshly filled frame pushes every live frame back
  function automatic void make_recent(input int s, input bit fresh, input logic [SW-1:0] old);
    for (int i = 0; i < NFRAMES; i++) begin
      if (i != s && frame_live[i] && (fresh || frame_age[i] < old))
        frame_age[i] = frame_age[i] + SW'(1);
    end
    frame_age[s] = '0;
  endfunction

  function automatic lrup_pkg::lrup_res_t lookup_and_replace(input lrup_pkg::lrup_req_t req);
    lrup_pkg::lrup_res_t r;
    int active;
    int hit_at;
    int empty_at;
    int victim;
    r = '0;
    hit_at = -1;
    empty_at = -1;
    victim = -1;
    active = (frames_setting == 0) ? 1 : (frames_setting > NFRAMES) ? NFRAMES : frames_setting;
    for (int i = 0; i < active; i++) begin
      if (frame_live[i] && frame_tag[i] == req.page_number) begin
        if (hit_at < 0) hit_at = i;
      end else if (!frame_live[i]) begin
        if (empty_at < 0) empty_at = i;
      end
    end
    if (hit_at >= 0) begin
      r.hit = 1'b1;
      r.slot = hit_at[SW-1:0];
      make_recent(hit_at, 1'b0, frame_age[hit_at]);
    end else begin
      if (faults_seen != '1) faults_seen = faults_seen + KW'(1);
      if (empty_at >= 0) begin
        r.slot = empty_at[SW-1:0];
        frame_tag[empty_at] = req.page_number;
        frame_live[empty_at] = 1'b1;
        make_recent(empty_at, 1'b1, '0);
      end else begin
        // oldest active frame, lowest index on a tie
        for (int i = 0; i < active; i++) begin
          if (victim < 0 || frame_age[i] > frame_age[victim]) victim = i;
        end
        r.slot = victim[SW-1:0];
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_tag[victim];
        frame_tag[victim] = req.page_number;
        make_recent(victim, 1'b0, frame_age[victim]);
      end
    end
    r.fault_total = faults_seen;
    r.string_done = req.last_request;
    if (req.last_request) empty_frames();
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    lrup_pkg::lrup_res_t want;
    if (!rst_n) begin
      empty_frames();
      frames_setting = lrup_pkg::FRAMES_RESET;
      pending_outcomes.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_outcomes.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected result, expected none, got %p", $time, out_res);
        end else begin
          want = pending_outcomes.pop_front();
          compare_field("hit", 64'(want.hit), 64'(out_res.hit));
          compare_field("slot", 64'(want.slot), 64'(out_res.slot));
          compare_field("evicted_valid", 64'(want.evicted_valid),
                        64'(out_res.evicted_valid));
          compare_field("evicted_page", 64'(want.evicted_page),
                        64'(out_res.evicted_page));
          compare_field("fault_total", 64'(want.fault_total), 64'(out_res.fault_total));
          compare_field("string_done", 64'(want.string_done), 64'(out_res.string_done));
        end
      end
      if (cfg_wr_en) frames_setting = cfg_wr_data;
      if (in_valid && !in_stall) pending_outcomes.push_back(lookup_and_replace(in_req));
    end
    mismatch_count <= errors;
    pending_count <= pending_outcomes.size();
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// top of the lru_page_replacement testbench: clock, reset, request and stall generation
// and the verdict; depends on lrup_pkg, lru_page_replacement and lrup_checker
module tb_top;

  localparam int RANDOM_ITEMS = 1880;
  localparam int TAIL_CYCLES = 24;
  localparam int IDLE_LIMIT = 2000;
  localparam int PW = lrup_pkg::PAGE_BITS;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  lrup_pkg::lrup_req_t        in_req = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  lrup_pkg::lrup_res_t        out_res;
  logic                       cfg_wr_en = 1'b0;
  logic [lrup_pkg::CFG_W-1:0] cfg_wr_data = '0;
  int unsigned                mismatch_count;
  int unsigned                pending_count;

  logic             rx_calm = 1'b0;
  int               stall_left = 0;
  int               run_left = 0;
  logic [PW-1:0]    page_pool [32];
  int               pool_size = 0;

  lru_page_replacement dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_res    (out_res),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  lrup_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req        (in_req),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_res       (out_res),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // mostly short, now and then long
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [PW-1:0] pick_page();
    logic [31:0] raw;
    raw = $urandom();
    if ($urandom_range(0, 99) < 85) return page_pool[5'($urandom_range(0, pool_size - 1))];
    return raw[PW-1:0];
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n || rx_calm) begin
      out_stall <= 1'b0;
      stall_left = 0;
      run_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (run_left > 0) begin
      out_stall <= 1'b0;
      run_left--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_stall <= 1'b1;
      stall_left = gap_length() - 1;
    end else begin
      out_stall <= 1'b0;
      run_left = $urandom_range(0, 30);
    end
  end

  // called at a rising edge, returns at a rising edge
  task automatic send_reference(input logic [PW-1:0] page, input logic last, input int gap);
    lrup_pkg::lrup_req_t req;
    req.page_number = page;
    req.last_request = last;
    in_req <= req;
    in_valid <= 1'b1;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_and_wait();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_frames(input logic [lrup_pkg::CFG_W-1:0] value);
    drain_and_wait();
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(negedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int sent;
    int batch;
    int active;
    logic [lrup_pkg::CFG_W-1:0] frames;
    logic calm;
    logic [31:0] raw;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // four frames out of reset: fill, hit, evict the oldest, end of string
    send_reference(20'h00000, 1'b0, 0);
    send_reference(20'hFFFFF, 1'b0, 0);
    send_reference(20'h00000, 1'b0, 0);
    send_reference(20'h00005, 1'b0, 1);
    send_reference(20'hAAAAA, 1'b0, 0);
    send_reference(20'h55555, 1'b0, 0);
    send_reference(20'h00000, 1'b0, 2);
    send_reference(20'hFFFFF, 1'b0, 0);
    send_reference(20'h55555, 1'b1, 0);
    send_reference(20'h00000, 1'b0, 0);
    // shrink to one frame with page zero still resident
    set_frames(5'd1);
    send_reference(20'h00000, 1'b0, 0);
    send_reference(20'h00007, 1'b0, 0);
    send_reference(20'h00007, 1'b1, 0);
    // zero frames acts as one
    set_frames(5'd0);
    send_reference(20'h00009, 1'b0, 0);
    send_reference(20'h0000A, 1'b0, 0);
    // above the maximum acts as sixteen
    set_frames(5'd31);
    send_reference(20'h0000B, 1'b0, 0);
    send_reference(20'h0000A, 1'b1, 0);
    set_frames(5'd17);
    send_reference(20'h00003, 1'b0, 0);
    send_reference(20'h00003, 1'b1, 0);
    set_frames(5'd16);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    frames = 5'd1;
        2, 3:    frames = 5'd16;
        4:       frames = $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(17, 31));
        default: frames = 5'($urandom_range(2, 15));
      endcase
      // strings run on across the write, so frames drop out and come back
      set_frames(frames);
      active = (frames == 0) ? 1 : (frames > 16) ? 16 : frames;
      calm = ($urandom_range(0, 3) == 0);
      rx_calm <= calm;
      if (pool_size == 0 || $urandom_range(0, 1) == 0) begin
        for (int i = 0; i < 32; i++) begin
          raw = $urandom();
          case ($urandom_range(0, 9))
            0:       page_pool[i] = '0;
            1:       page_pool[i] = '1;
            default: page_pool[i] = raw[PW-1:0];
          endcase
        end
      end
      pool_size = $urandom_range(1, active + 4);
      batch = $urandom_range(20, 100);
      repeat (batch) begin
        send_reference(pick_page(), ($urandom_range(0, 49) == 0),
                       (calm || $urandom_range(0, 9) < 6) ? 0 : gap_length());
        sent++;
      end
    end

    rx_calm <= 1'b0;
    drain_and_wait();
    @(negedge clk);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (pending_count != 0) $display("%0d results never arrived", pending_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
